[rtl/sahbs_pkg.sv]
// Shared types and constants for the binned SAH split search unit.
package sahbs_pkg;
  localparam logic [62:0] COST_MAX = {63{1'b1}};

  // bins per axis; bin_index and best_bin are four bits wide
  localparam int BINS = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREFIX,
    ST_SUFFIX,
    ST_AREA,
    ST_COST,
    ST_EMIT
  } state_t;

  // saturating add of two 63-bit costs
  function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? COST_MAX : s[62:0];
  endfunction
endpackage

[rtl/sahbs_area.sv]
// Registered surface area of one box: three extent products, then sum.
module sahbs_area #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic signed [3*COORD_BITS-1:0] lo,
  input  logic signed [3*COORD_BITS-1:0] hi,
  output logic [62:0]                  area
);
  localparam int DW = COORD_BITS + 1;
  logic [DW-1:0] d [3];
  logic [2*DW-1:0] p [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [DW-1:0] e;
      e = DW'(signed'(hi[k*COORD_BITS +: COORD_BITS])) -
          DW'(signed'(lo[k*COORD_BITS +: COORD_BITS]));
      d[k] = e[DW-1] ? '0 : DW'(e);
    end
  end

  always_ff @(posedge clk) begin
    p[0] <= d[0] * d[1];
    p[1] <= d[1] * d[2];
    p[2] <= d[2] * d[0];
  end

  // products fit well under 2^62, so the doubled sum never saturates at these widths
  always_comb begin
    logic [62:0] s;
    s = sahbs_pkg::sat_add(sahbs_pkg::sat_add(63'(p[0]), 63'(p[1])), 63'(p[2]));
    area = s[62] ? sahbs_pkg::COST_MAX : {s[61:0], 1'b0};
  end
endmodule

[rtl/sah_binned_split_search_unit.sv]
// Top level: bin memories, prefix/suffix sweeps and cost compare.
//  channel | dir | words
//  in      | in  | one bin per word (axis, bin_index, count, box, last_of_node)
//  out     | out | one split result per node, on last_of_node
// A bin word that is not bin BINS-1 is stored in the bin memory. Bin BINS-1
// runs a prefix pass, a suffix pass, an area state and a cost pass (until the last
// compare lands). Synchronous reset clears control only.
// in stall stays high while an axis is evaluated or a result is held on out until taken.
module sah_binned_split_search_unit #(
  parameter int COORD_BITS = 20,
  parameter int COUNT_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   axis,
  input  logic [3:0]                   bin_index,
  input  logic [COUNT_BITS-1:0]        prim_count,
  input  logic signed [COORD_BITS-1:0] min_x,
  input  logic signed [COORD_BITS-1:0] min_y,
  input  logic signed [COORD_BITS-1:0] min_z,
  input  logic signed [COORD_BITS-1:0] max_x,
  input  logic signed [COORD_BITS-1:0] max_y,
  input  logic signed [COORD_BITS-1:0] max_z,
  input  logic                         last_of_node,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [1:0]                   best_axis,
  output logic [3:0]                   best_bin,
  output logic [62:0]                  best_cost
);
  localparam int BINS = sahbs_pkg::BINS;
  localparam int IW = $clog2(BINS);
  localparam int BW = 3 * COORD_BITS;
  localparam int TW = COUNT_BITS + IW + 1;
  // box area stays below 2^(2*COORD_BITS+3)
  localparam int AW = 2 * COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] crd_t;

  logic [BW-1:0]         bmin_mem [BINS];
  logic [BW-1:0]         bmax_mem [BINS];
  logic [COUNT_BITS-1:0] bcnt_mem [BINS];
  logic [BW-1:0]         pmin_mem [BINS];
  logic [BW-1:0]         pmax_mem [BINS];
  logic [TW-1:0]         left_mem [BINS];
  logic [62:0]           rarea_mem [BINS];

  sahbs_pkg::state_t state, state_next;
  logic [IW:0]   idx;
  logic [IW-1:0] ridx;
  logic [1:0]    cur_axis;
  logic          pend_last;
  logic          rd_en;
  logic [BW-1:0] rmin, rmax, rpmin, rpmax;
  logic [COUNT_BITS-1:0] rcnt;
  logic [TW-1:0] rleft;
  logic [62:0]   rrarea;
  logic          rd_vld, rd_vld2;
  logic [IW-1:0] rd_i, rd_i2;
  logic          u_vld;
  logic [BW-1:0] u_lo, u_hi;
  logic [TW-1:0] total;
  logic [63:0]   cheap_cost;
  logic [1:0]    cheap_axis;
  logic [3:0]    cheap_bin;
  logic          have_split;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != sahbs_pkg::ST_LOAD);

  // union of running box with bin just read
  logic [BW-1:0] m_lo, m_hi;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_t a, b, c, e;
      a = crd_t'(u_lo[k*COORD_BITS +: COORD_BITS]);
      b = crd_t'(rmin[k*COORD_BITS +: COORD_BITS]);
      c = crd_t'(u_hi[k*COORD_BITS +: COORD_BITS]);
      e = crd_t'(rmax[k*COORD_BITS +: COORD_BITS]);
      m_lo[k*COORD_BITS +: COORD_BITS] = (!u_vld || b < a) ? b : a;
      m_hi[k*COORD_BITS +: COORD_BITS] = (!u_vld || e > c) ? e : c;
    end
  end
  logic          take;
  logic [BW-1:0] n_lo, n_hi;
  assign take = rcnt != '0;
  assign n_lo = take ? m_lo : u_lo;
  assign n_hi = take ? m_hi : u_hi;

  // area unit: suffix uses union, cost uses prefix memory
  logic [BW-1:0] a_lo, a_hi;
  logic [62:0]   area;
  assign a_lo = (state == sahbs_pkg::ST_COST) ? rpmin : n_lo;
  assign a_hi = (state == sahbs_pkg::ST_COST) ? rpmax : n_hi;
  sahbs_area #(.COORD_BITS(COORD_BITS)) u_area (
    .clk(clk), .lo(a_lo), .hi(a_hi), .area(area));

  always_comb begin
    state_next = state;
    unique case (state)
      sahbs_pkg::ST_LOAD: begin
        if (accept) begin
          if (32'(bin_index) == BINS - 1) state_next = sahbs_pkg::ST_PREFIX;
          else if (last_of_node) state_next = sahbs_pkg::ST_EMIT;
        end
      end
      sahbs_pkg::ST_PREFIX: if (rd_vld && 32'(rd_i) == BINS - 1) state_next = sahbs_pkg::ST_SUFFIX;
      sahbs_pkg::ST_SUFFIX: if (rd_vld && rd_i == '0) state_next = sahbs_pkg::ST_AREA;
      sahbs_pkg::ST_AREA:   state_next = sahbs_pkg::ST_COST;
      // leave once the read pipe is drained and the last compare lands
      sahbs_pkg::ST_COST:
        if (!rd_en && !rd_vld && !rd_vld2)
          state_next = pend_last ? sahbs_pkg::ST_EMIT : sahbs_pkg::ST_LOAD;
      sahbs_pkg::ST_EMIT:   if (!out_stall) state_next = sahbs_pkg::ST_LOAD;
      default:              state_next = sahbs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    ridx = idx[IW-1:0];
    unique case (state)
      sahbs_pkg::ST_PREFIX: rd_en = 32'(idx) < BINS;
      sahbs_pkg::ST_SUFFIX: rd_en = !idx[IW];
      sahbs_pkg::ST_COST:   rd_en = 32'(idx) < BINS - 1;
      default:              rd_en = 1'b0;
    endcase
  end

  assign out_valid = (state == sahbs_pkg::ST_EMIT);
  assign found     = have_split;
  assign best_axis = have_split ? cheap_axis : 2'd0;
  assign best_bin  = have_split ? cheap_bin : 4'd0;
  assign best_cost = have_split ? cheap_cost[62:0] : 63'd0;

  // memories
  always_ff @(posedge clk) begin
    if (accept && 32'(bin_index) < BINS) begin
      bmin_mem[bin_index[IW-1:0]] <= {min_z, min_y, min_x};
      bmax_mem[bin_index[IW-1:0]] <= {max_z, max_y, max_x};
      bcnt_mem[bin_index[IW-1:0]] <= prim_count;
    end
    if (rd_en) begin
      rmin  <= bmin_mem[ridx];
      rmax  <= bmax_mem[ridx];
      rcnt  <= bcnt_mem[ridx];
      rpmin <= pmin_mem[ridx];
      rpmax <= pmax_mem[ridx];
      rleft <= left_mem[ridx];
      rrarea <= rarea_mem[ridx];
    end
    if (state == sahbs_pkg::ST_PREFIX && rd_vld) begin
      pmin_mem[rd_i] <= n_lo;
      pmax_mem[rd_i] <= n_hi;
      left_mem[rd_i] <= total + TW'(rcnt);
    end
    // area of suffix union bins i+1.. lands at index i, from the area unit's registered products
    if (state == sahbs_pkg::ST_SUFFIX || state == sahbs_pkg::ST_AREA) begin
      if (rd_vld2 && rd_i2 != '0)
        rarea_mem[rd_i2 - 1'b1] <= u_vld ? area : 63'd0;
    end
  end

  // cost of boundary rd_i2: prefix area arrives from the area unit, whose products are registered
  logic [TW-1:0] nl, nr;
  logic [62:0]   ra_q;
  logic [TW-1:0] nl_q, nr_q;
  logic [62:0]   ml, mr;
  logic          c_vld;
  logic [IW-1:0] c_i;
  assign nl = rleft;
  assign nr = total - rleft;

  // only the low AW bits of an area can be set; anything above saturates
  function automatic logic [62:0] sat_mul(input logic [62:0] a, input logic [TW-1:0] b);
    logic [AW+TW-1:0] p;
    p = AW'(a) * b;
    if (a[62:AW] != '0) return sahbs_pkg::COST_MAX;
    return (p > (AW+TW)'(sahbs_pkg::COST_MAX)) ? sahbs_pkg::COST_MAX : 63'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sahbs_pkg::ST_LOAD;
      idx <= '0;
      rd_vld <= 1'b0;
      rd_vld2 <= 1'b0;
      c_vld <= 1'b0;
      pend_last <= 1'b0;
      cheap_cost <= '1;
      cheap_axis <= '0;
      cheap_bin <= '0;
      have_split <= 1'b0;
      u_vld <= 1'b0;
      total <= '0;
    end else begin
      state <= state_next;
      rd_vld <= rd_en;
      rd_i <= ridx;
      rd_vld2 <= rd_vld;
      rd_i2 <= rd_i;
      if (state == sahbs_pkg::ST_LOAD && accept) begin
        cur_axis <= axis;
        pend_last <= last_of_node;
        idx <= '0;
        u_vld <= 1'b0;
        total <= '0;
      end
      if (state == sahbs_pkg::ST_PREFIX) begin
        if (rd_en) idx <= idx + 1'b1;
        if (rd_vld) begin
          u_lo <= n_lo; u_hi <= n_hi;
          u_vld <= (32'(rd_i) == BINS - 1) ? 1'b0 : (u_vld | take);
          total <= total + TW'(rcnt);
          if (32'(rd_i) == BINS - 1) begin
            idx <= (IW+1)'(BINS - 1);
          end
        end
      end
      if (state == sahbs_pkg::ST_SUFFIX) begin
        if (rd_en) idx <= (idx == '0) ? {1'b1, {IW{1'b0}}} : idx - 1'b1;
        if (rd_vld) begin
          u_lo <= n_lo; u_hi <= n_hi; u_vld <= u_vld | take;
        end
      end
      if (state == sahbs_pkg::ST_AREA) idx <= '0;
      if (state == sahbs_pkg::ST_COST) begin
        if (rd_en) idx <= idx + 1'b1;
        nl_q <= nl; nr_q <= nr; ra_q <= rrarea;
        c_vld <= rd_vld2 && nl_q != '0 && nr_q != '0;
        c_i <= rd_i2;
        ml <= sat_mul(area, nl_q);
        mr <= sat_mul(ra_q, nr_q);
      end else begin
        c_vld <= 1'b0;
      end
      if (c_vld) begin
        if ({1'b0, sahbs_pkg::sat_add(ml, mr)} < cheap_cost) begin
          cheap_cost <= {1'b0, sahbs_pkg::sat_add(ml, mr)};
          cheap_axis <= cur_axis;
          cheap_bin <= 4'(c_i);
          have_split <= 1'b1;
        end
      end
      if (state == sahbs_pkg::ST_EMIT && !out_stall) begin
        cheap_cost <= '1;
        cheap_axis <= '0;
        cheap_bin <= '0;
        have_split <= 1'b0;
        pend_last <= 1'b0;
      end
    end
  end
endmodule

[dv/tb_top.sv]
// Testbench for the binned SAH split search unit: directed and random nodes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 16;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic        found;
    logic [1:0]  axis;
    logic [3:0]  bin;
    logic [62:0] cost;
  } split_t;

  typedef struct {
    logic [1:0]  axis;
    logic [3:0]  idx;
    logic [19:0] cnt;
    logic [19:0] lo [3];
    logic [19:0] hi [3];
    logic        last;
  } bin_word_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, last_of_node = 0;
  logic [1:0] axis = 0;
  logic [3:0] bin_index = 0;
  logic [19:0] prim_count = 0;
  logic signed [19:0] min_x = 0, min_y = 0, min_z = 0, max_x = 0, max_y = 0, max_z = 0;
  logic found;
  logic [1:0] best_axis;
  logic [3:0] best_bin;
  logic [62:0] best_cost;

  sah_binned_split_search_unit dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  longint          bin_lo [NBINS][3];
  longint          bin_hi [NBINS][3];
  longint unsigned bin_cnt [NBINS];
  logic [63:0]     cheap_cost = '1;
  logic [1:0]      cheap_axis = 0;
  logic [3:0]      cheap_bin = 0;
  logic            have_split = 0;

  split_t split_q[$];
  int     mismatches = 0;
  int     items_sent = 0;
  bit     idle_on = 1;
  int     out_hold = 0;
  int     quiet_cycles = 0;

  function automatic logic [62:0] cap_add(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? sahbs_pkg::COST_MAX : s[62:0];
  endfunction

  function automatic logic [62:0] cap_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return (p > 128'(sahbs_pkg::COST_MAX)) ? sahbs_pkg::COST_MAX : p[62:0];
  endfunction

  function automatic logic [62:0] surface_area(longint lo[3], longint hi[3]);
    longint unsigned d[3];
    for (int k = 0; k < 3; k++) d[k] = (hi[k] > lo[k]) ? hi[k] - lo[k] : 0;
    return cap_mul(64'd2, 64'(cap_add(cap_add(63'(d[0] * d[1]), 63'(d[1] * d[2])),
                                      63'(d[2] * d[0]))));
  endfunction

  function automatic void grow_box(inout bit ok, inout longint lo[3], inout longint hi[3],
                                   input int b);
    for (int k = 0; k < 3; k++) begin
      if (!ok || bin_lo[b][k] < lo[k]) lo[k] = bin_lo[b][k];
      if (!ok || bin_hi[b][k] > hi[k]) hi[k] = bin_hi[b][k];
    end
    ok = 1;
  endfunction

  function automatic void sweep_axis(logic [1:0] ax);
    longint          lo[3], hi[3], plo[NBINS][3], phi[NBINS][3];
    longint unsigned left[NBINS], rarea[NBINS], total, nl, nr;
    logic [62:0]     cost;
    bit              ok;
    ok = 0; total = 0;
    lo = '{0, 0, 0}; hi = '{0, 0, 0};
    for (int i = 0; i < NBINS; i++) begin
      if (bin_cnt[i] != 0) grow_box(ok, lo, hi, i);
      plo[i] = lo; phi[i] = hi;
      total += bin_cnt[i];
      left[i] = total;
    end
    ok = 0;
    lo = '{0, 0, 0}; hi = '{0, 0, 0};
    for (int i = NBINS - 2; i >= 0; i--) begin
      if (bin_cnt[i+1] != 0) grow_box(ok, lo, hi, i + 1);
      rarea[i] = ok ? 64'(surface_area(lo, hi)) : 64'd0;
    end
    for (int i = 0; i < NBINS - 1; i++) begin
      nl = left[i];
      nr = total - nl;
      if (nl != 0 && nr != 0) begin
        cost = cap_add(cap_mul(64'(surface_area(plo[i], phi[i])), nl),
                       cap_mul(rarea[i], nr));
        if ({1'b0, cost} < cheap_cost) begin
          cheap_cost = {1'b0, cost};
          cheap_axis = ax;
          cheap_bin = i[3:0];
          have_split = 1;
        end
      end
    end
  endfunction

  function automatic void predict_word(bin_word_t w);
    split_t r;
    bin_cnt[w.idx] = 64'(w.cnt);
    for (int k = 0; k < 3; k++) begin
      bin_lo[w.idx][k] = longint'($signed(w.lo[k]));
      bin_hi[w.idx][k] = longint'($signed(w.hi[k]));
    end
    if (w.idx == NBINS - 1) sweep_axis(w.axis);
    if (w.last) begin
      r = have_split ? {1'b1, cheap_axis, cheap_bin, cheap_cost[62:0]} : '0;
      split_q.push_back(r);
      cheap_cost = '1; cheap_axis = 0; cheap_bin = 0; have_split = 0;
    end
  endfunction

  task automatic send_word(bin_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    axis <= w.axis; bin_index <= w.idx; prim_count <= w.cnt; last_of_node <= w.last;
    min_x <= w.lo[0]; min_y <= w.lo[1]; min_z <= w.lo[2];
    max_x <= w.hi[0]; max_y <= w.hi[1]; max_z <= w.hi[2];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    items_sent++;
  endtask

  function automatic bin_word_t rand_word(int style);
    bin_word_t w;
    logic [19:0] c;
    w.axis = 2'($urandom_range(0, 3));
    w.idx = 4'($urandom_range(0, 15));
    w.last = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 3))
      0: w.cnt = '0;
      1: w.cnt = 20'($urandom_range(1, 8));
      2: w.cnt = '1;
      default: w.cnt = 20'($urandom);
    endcase
    for (int k = 0; k < 3; k++) begin
      if (style == 0) begin
        w.lo[k] = 20'($urandom); w.hi[k] = 20'($urandom);
      end else begin
        // mostly well-formed boxes, sometimes inverted unless style 2 flattens them
        c = 20'($urandom);
        w.lo[k] = c;
        w.hi[k] = ($urandom_range(0, 9) == 0) ? c - 20'($urandom_range(1, 500))
                                              : c + 20'($urandom_range(0, 5000));
        if ($signed(w.hi[k]) < $signed(w.lo[k]) && style == 2) w.hi[k] = c;
      end
    end
    return w;
  endfunction

  task automatic send_node(int style);
    bin_word_t w, twin;
    bit ties;
    ties = ($urandom_range(0, 5) == 0);
    twin = rand_word(style);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < NBINS; b++) begin
        w = ties ? twin : rand_word(style);
        if ($urandom_range(0, 2) == 0 && !ties) w.cnt = 20'($urandom_range(0, 3));
        w.axis = 2'(a); w.idx = 4'(b);
        w.last = (a == 2 && b == NBINS - 1);
        send_word(w);
      end
  endtask

  task automatic test_extremes;
    bin_word_t w;
    for (int b = 0; b < NBINS; b++) begin
      w.axis = 2'd0; w.idx = 4'(b); w.last = (b == NBINS - 1);
      w.cnt = (b % 3 == 0) ? 20'hFFFFF : (b % 3 == 1) ? 20'd0 : 20'd1;
      for (int k = 0; k < 3; k++) begin
        w.lo[k] = (b < 8) ? 20'h80000 : 20'h00010;
        w.hi[k] = (b == 5) ? 20'h80000 : 20'h7FFFF;
      end
      send_word(w);
    end
  endtask

  task automatic test_special_cases;
    bin_word_t w;
    w = rand_word(1);
    // early last: no axis evaluation, empty result
    w.idx = 4'd3; w.last = 1;
    send_word(w);
    // axis three, single bin update then evaluation on the top bin
    w = rand_word(1);
    w.axis = 2'd3; w.idx = 4'(NBINS - 1); w.cnt = 20'd7; w.last = 1;
    send_word(w);
    // empty top bin; any split comes from the other stored bins
    w = rand_word(1);
    w.axis = 2'd2; w.idx = 4'(NBINS - 1); w.cnt = '0; w.last = 1;
    send_word(w);
  endtask

  task automatic test_random;
    while (items_sent < 1400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 12)) send_word(rand_word(0));
      else
        send_node($urandom_range(0, 2));
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1;
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    split_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {found, best_axis, best_bin, best_cost};
      out_hold <= idle_on ? $urandom_range(0, 14) : 0;
      if (split_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = split_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%b axis=%0d bin=%0d cost=%0d",
                     want.found, want.axis, want.bin, want.cost,
                     " got found=%b axis=%0d bin=%0d cost=%0d",
                     got.found, got.axis, got.bin, got.cost);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_extremes();
    test_special_cases();
    test_random();
    @(negedge clk);
    in_valid <= 0;
    while (split_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/sahbs_pkg.sv
rtl/sahbs_area.sv
rtl/sah_binned_split_search_unit.sv
dv/tb_top.sv
